// File: src/assert_macros.svh
// Assertion macros for the instruction encoder.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define XIE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define XIE_ASSERT_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define XIE_ASSERT(label, clk, rst, prop, msg)
`define XIE_ASSERT_ANY(label, clk, prop, msg)
`endif
`endif

// File: src/xie_pkg.sv
// Types and constants shared by the x86-64 instruction encoder.
// No dependencies.
`default_nettype none
package xie_pkg;

  localparam int MAX_BYTES = 10;
  localparam int LEN_W     = 4;

  typedef enum logic [4:0] {
    OP_MOVIMM64 = 5'd0,
    OP_MOVRR    = 5'd1,
    OP_LOAD     = 5'd2,
    OP_ADD      = 5'd3,
    OP_SUB      = 5'd4,
    OP_IMUL     = 5'd5,
    OP_CMP      = 5'd6,
    OP_CMPIMM   = 5'd7,
    OP_JLE      = 5'd8,
    OP_JG       = 5'd9,
    OP_JMP      = 5'd10,
    OP_CALL     = 5'd11,
    OP_RET      = 5'd12,
    OP_PUSH     = 5'd13,
    OP_POP      = 5'd14,
    OP_LEA      = 5'd15,
    OP_TEST     = 5'd16,
    OP_JE       = 5'd17,
    OP_SETLE    = 5'd18,
    OP_SETL     = 5'd19,
    OP_SETE     = 5'd20,
    OP_SETNE    = 5'd21,
    OP_MOVZX    = 5'd22,
    OP_ADDIMM   = 5'd23
  } op_e;

  localparam logic [7:0] REX_W      = 8'h48;
  localparam logic [7:0] REX_B_ONLY = 8'h41;
  localparam logic [7:0] MOD_REG    = 8'hC0;
  localparam logic [7:0] MOD_DISP32 = 8'h80;
  localparam logic [7:0] SIB_RSP    = 8'h24;
  localparam logic [7:0] ESC_0F     = 8'h0F;
  localparam logic [7:0] OPC_MOVRM  = 8'h89;
  localparam logic [7:0] OPC_LOAD   = 8'h8B;
  localparam logic [7:0] OPC_LEA    = 8'h8D;
  localparam logic [7:0] OPC_ADD    = 8'h01;
  localparam logic [7:0] OPC_SUB    = 8'h29;
  localparam logic [7:0] OPC_CMP    = 8'h39;
  localparam logic [7:0] OPC_TEST   = 8'h85;
  localparam logic [7:0] OPC_IMUL   = 8'hAF;
  localparam logic [7:0] OPC_MOVZX  = 8'hB6;
  localparam logic [7:0] OPC_GRP1   = 8'h81;
  localparam logic [7:0] OPC_CMPACC = 8'h3D;
  localparam logic [7:0] OPC_ADDACC = 8'h05;
  localparam logic [7:0] OPC_JLE    = 8'h8E;
  localparam logic [7:0] OPC_JG     = 8'h8F;
  localparam logic [7:0] OPC_JE     = 8'h84;
  localparam logic [7:0] OPC_JMP8   = 8'hEB;
  localparam logic [7:0] OPC_JMP32  = 8'hE9;
  localparam logic [7:0] OPC_GRP5   = 8'hFF;
  localparam logic [7:0] OPC_RET    = 8'hC3;
  localparam logic [7:0] OPC_PUSH   = 8'h50;
  localparam logic [7:0] OPC_POP    = 8'h58;
  localparam logic [7:0] OPC_MOVIMM = 8'hB8;
  localparam logic [7:0] OPC_SETLE  = 8'h9E;
  localparam logic [7:0] OPC_SETL   = 8'h9C;
  localparam logic [7:0] OPC_SETE   = 8'h94;
  localparam logic [7:0] OPC_SETNE  = 8'h95;

  localparam logic [2:0] EXT_ADD  = 3'd0;
  localparam logic [2:0] EXT_CALL = 3'd2;
  localparam logic [2:0] EXT_CMP  = 3'd7;
  localparam logic [2:0] REG_RSP  = 3'd4;

  localparam logic [LEN_W-1:0] TAIL_NONE = 4'd0;
  localparam logic [LEN_W-1:0] TAIL_REL8 = 4'd1;
  localparam logic [LEN_W-1:0] TAIL_32   = 4'd4;
  localparam logic [LEN_W-1:0] TAIL_64   = 4'd8;

  typedef struct packed {
    logic [4:0]         opcode;
    logic [3:0]         first_reg;
    logic [3:0]         second_reg;
    logic signed [63:0] immediate;
  } req_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } res_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [LEN_W-1:0]          len;
  } plan_t;

endpackage
`default_nettype wire

// File: src/xie_front.sv
// Front end: classifies one request and lays out its full byte sequence.
// Depends on xie_pkg.
`default_nettype none
module xie_front (
  input  wire xie_pkg::req_t  req,
  output xie_pkg::plan_t      plan
);

  logic [3:0]       a;
  logic [3:0]       b;
  logic [3:0][7:0]  raw;
  logic [2:0]       rc;
  logic             pre;
  logic [3:0]       tn;
  logic [3:0][7:0]  h;
  logic [2:0]       hc;
  logic [7:0][7:0]  imm_b;
  logic [7:0]       rex_ab;
  logic [7:0]       rex_ba;
  logic [7:0]       rex_0a;
  logic [7:0]       rr_ba;
  logic [7:0]       rr_ab;
  logic [7:0]       mem_ab;
  logic             sib;
  logic             jmp_short;
  logic [3:0]       t;

  assign a      = req.first_reg;
  assign b      = req.second_reg;
  assign imm_b  = req.immediate;
  assign rex_ab = xie_pkg::REX_W | {5'b0, a[3], 1'b0, b[3]};
  assign rex_ba = xie_pkg::REX_W | {5'b0, b[3], 1'b0, a[3]};
  assign rex_0a = xie_pkg::REX_W | {7'b0, a[3]};
  assign rr_ba  = xie_pkg::MOD_REG | {2'b0, b[2:0], a[2:0]};
  assign rr_ab  = xie_pkg::MOD_REG | {2'b0, a[2:0], b[2:0]};
  assign mem_ab = xie_pkg::MOD_DISP32 | {2'b0, a[2:0], b[2:0]};
  assign sib    = (b[2:0] == xie_pkg::REG_RSP);
  assign jmp_short = (&req.immediate[31:7]) | ~(|req.immediate[31:7]);

  always_comb begin
    raw = '0;
    rc  = 3'd0;
    pre = 1'b0;
    tn  = xie_pkg::TAIL_NONE;
    case (req.opcode)
      xie_pkg::OP_MOVIMM64: begin
        raw[0] = xie_pkg::REX_W | {7'b0, a[3]};
        raw[1] = xie_pkg::OPC_MOVIMM + {5'b0, a[2:0]};
        rc = 3'd2;
        tn = xie_pkg::TAIL_64;
      end
      xie_pkg::OP_MOVRR, xie_pkg::OP_ADD, xie_pkg::OP_SUB, xie_pkg::OP_CMP,
      xie_pkg::OP_TEST: begin
        raw[0] = rex_ba;
        case (req.opcode)
          xie_pkg::OP_MOVRR: raw[1] = xie_pkg::OPC_MOVRM;
          xie_pkg::OP_ADD:   raw[1] = xie_pkg::OPC_ADD;
          xie_pkg::OP_SUB:   raw[1] = xie_pkg::OPC_SUB;
          xie_pkg::OP_CMP:   raw[1] = xie_pkg::OPC_CMP;
          default:           raw[1] = xie_pkg::OPC_TEST;
        endcase
        raw[2] = rr_ba;
        rc = 3'd3;
      end
      xie_pkg::OP_LOAD, xie_pkg::OP_LEA: begin
        raw[0] = rex_ab;
        raw[1] = (req.opcode == xie_pkg::OP_LOAD) ? xie_pkg::OPC_LOAD : xie_pkg::OPC_LEA;
        raw[2] = mem_ab;
        raw[3] = xie_pkg::SIB_RSP;
        rc = sib ? 3'd4 : 3'd3;
        tn = xie_pkg::TAIL_32;
      end
      xie_pkg::OP_IMUL, xie_pkg::OP_MOVZX: begin
        raw[0] = rex_ab;
        raw[1] = xie_pkg::ESC_0F;
        raw[2] = (req.opcode == xie_pkg::OP_IMUL) ? xie_pkg::OPC_IMUL : xie_pkg::OPC_MOVZX;
        raw[3] = rr_ab;
        rc = 3'd4;
      end
      xie_pkg::OP_CMPIMM, xie_pkg::OP_ADDIMM: begin
        if (a == 4'd0) begin
          raw[0] = xie_pkg::REX_W;
          raw[1] = (req.opcode == xie_pkg::OP_CMPIMM) ? xie_pkg::OPC_CMPACC
                                                       : xie_pkg::OPC_ADDACC;
          rc = 3'd2;
        end else begin
          raw[0] = rex_0a;
          raw[1] = xie_pkg::OPC_GRP1;
          raw[2] = xie_pkg::MOD_REG | {2'b0,
                   (req.opcode == xie_pkg::OP_CMPIMM) ? xie_pkg::EXT_CMP : xie_pkg::EXT_ADD,
                   a[2:0]};
          rc = 3'd3;
        end
        tn = xie_pkg::TAIL_32;
      end
      xie_pkg::OP_JLE, xie_pkg::OP_JG, xie_pkg::OP_JE: begin
        raw[0] = xie_pkg::ESC_0F;
        case (req.opcode)
          xie_pkg::OP_JLE: raw[1] = xie_pkg::OPC_JLE;
          xie_pkg::OP_JG:  raw[1] = xie_pkg::OPC_JG;
          default:         raw[1] = xie_pkg::OPC_JE;
        endcase
        rc = 3'd2;
        tn = xie_pkg::TAIL_32;
      end
      xie_pkg::OP_JMP: begin
        raw[0] = jmp_short ? xie_pkg::OPC_JMP8 : xie_pkg::OPC_JMP32;
        rc = 3'd1;
        tn = jmp_short ? xie_pkg::TAIL_REL8 : xie_pkg::TAIL_32;
      end
      xie_pkg::OP_CALL: begin
        pre = a[3];
        raw[0] = xie_pkg::OPC_GRP5;
        raw[1] = xie_pkg::MOD_REG | {2'b0, xie_pkg::EXT_CALL, a[2:0]};
        rc = 3'd2;
      end
      xie_pkg::OP_RET: begin
        raw[0] = xie_pkg::OPC_RET;
        rc = 3'd1;
      end
      xie_pkg::OP_PUSH, xie_pkg::OP_POP: begin
        pre = a[3];
        raw[0] = ((req.opcode == xie_pkg::OP_PUSH) ? xie_pkg::OPC_PUSH : xie_pkg::OPC_POP)
                 + {5'b0, a[2:0]};
        rc = 3'd1;
      end
      xie_pkg::OP_SETLE, xie_pkg::OP_SETL, xie_pkg::OP_SETE, xie_pkg::OP_SETNE: begin
        pre = a[3];
        raw[0] = xie_pkg::ESC_0F;
        case (req.opcode)
          xie_pkg::OP_SETLE: raw[1] = xie_pkg::OPC_SETLE;
          xie_pkg::OP_SETL:  raw[1] = xie_pkg::OPC_SETL;
          xie_pkg::OP_SETE:  raw[1] = xie_pkg::OPC_SETE;
          default:           raw[1] = xie_pkg::OPC_SETNE;
        endcase
        raw[2] = xie_pkg::MOD_REG | {5'b0, a[2:0]};
        rc = 3'd3;
      end
      default: begin
        rc = 3'd0;
      end
    endcase
  end

  // shift in the REX.B prefix ahead of the body
  always_comb begin
    h[0] = pre ? xie_pkg::REX_B_ONLY : raw[0];
    h[1] = pre ? raw[0] : raw[1];
    h[2] = pre ? raw[1] : raw[2];
    h[3] = pre ? raw[2] : raw[3];
    hc   = rc + {2'b0, pre};
  end

  always_comb begin
    plan.len = {1'b0, hc} + tn;
    t = '0;
    for (int k = 0; k < xie_pkg::MAX_BYTES; k++) begin
      t = 4'(k) - {1'b0, hc};
      if (4'(k) < {1'b0, hc}) begin
        plan.bytes[k] = h[2'(k)];
      end else begin
        plan.bytes[k] = imm_b[t[2:0]];
      end
    end
  end

endmodule
`default_nettype wire

// File: src/xie_queue.sv
// Short queue of laid-out instructions between front and back.
// Depends on xie_pkg.
`default_nettype none
module xie_queue #(
  parameter int DEPTH = 2
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 wr_en,
  input  wire xie_pkg::plan_t wr_data,
  output logic                q_full,
  output logic                q_empty,
  input  wire                 rd_en,
  output xie_pkg::plan_t      rd_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  xie_pkg::plan_t   entry [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign q_full  = (count == CW'(DEPTH));
  assign q_empty = (count == '0);
  assign rd_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/xie_back.sv
// Back end: walks the head instruction one byte per cycle into an output register; an unpopped byte holds it.
// Depends on xie_pkg.
`default_nettype none
module xie_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire xie_pkg::plan_t head,
  input  wire                 head_valid,
  output logic                head_take,
  input  wire                 pop,
  output logic                empty,
  output xie_pkg::res_t       res
);

  logic [xie_pkg::LEN_W-1:0] idx;
  logic [xie_pkg::LEN_W-1:0] idx_next;
  logic                      out_valid;
  logic                      load;
  logic                      at_last;

  assign empty     = ~out_valid;
  assign load      = ~out_valid | pop;
  assign at_last   = (idx == head.len - 1'b1);
  assign head_take = load & head_valid & at_last;
  assign idx_next  = at_last ? '0 : idx + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        idx <= idx_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      res.code_byte <= head.bytes[idx];
      res.last_byte <= at_last;
    end
  end

endmodule
`default_nettype wire

// File: src/x86_64_instruction_encoder.sv
// Channel   Ports              Handshake
// request   req (req_t)        push / full
// byte out  res (res_t)        pop / empty
//
// One byte leaves per cycle while pop is high and a byte waits; an instruction
// has 1 to 10 bytes, which the single byte serialiser sends in order.
// A request is taken every cycle while the DEPTH-entry queue has room.
// The first byte is registered in the queue entry, then in the output register.
// Synchronous reset empties the queue and the output register; no clearing pass.
// Unused form codes are taken and produce no bytes.
`default_nettype none
`include "assert_macros.svh"
module x86_64_instruction_encoder #(
  parameter int DEPTH = 2
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  output logic               full,
  input  wire xie_pkg::req_t req,
  output logic               empty,
  input  wire                pop,
  output xie_pkg::res_t      res
);

  xie_pkg::plan_t plan;
  xie_pkg::plan_t head;
  logic           q_push;
  logic           q_full;
  logic           q_empty;
  logic           head_take;

  xie_front u_front (
    .req  (req),
    .plan (plan)
  );

  // drop unused forms at the queue entrance
  assign q_push = push & ~q_full & (plan.len != '0);
  assign full   = q_full;

  xie_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (plan),
    .q_full  (q_full),
    .q_empty (q_empty),
    .rd_en   (head_take),
    .rd_data (head)
  );

  xie_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (~q_empty),
    .head_take  (head_take),
    .pop        (pop),
    .empty      (empty),
    .res        (res)
  );

  `XIE_ASSERT(a_head_len, clk, rst, !q_empty |-> (head.len != '0 && head.len <= 4'd10), "queued instruction length out of range")
  `XIE_ASSERT(a_take_nonempty, clk, rst, head_take |-> !q_empty, "queue read while empty")
  `XIE_ASSERT(a_res_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(res)), "waiting word not held")
  `XIE_ASSERT_ANY(a_reset_idle, clk, $past(rst) |-> (empty && !full), "not idle after reset")

endmodule
`default_nettype wire

// File: sim/x86_64_instruction_encoder_test.sv
// Self-checking bench for x86_64_instruction_encoder: request words in, code bytes out.
// Expected bytes are worked out by an encoder model in this file under random idling.
// Depends on xie_pkg and the encoder RTL.
module x86_64_instruction_encoder_test;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS  = 48;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  xie_pkg::req_t req = '0;
  logic full;
  logic empty;
  xie_pkg::res_t res;

  xie_pkg::req_t pending_requests[$];
  xie_pkg::res_t expected_bytes[$];
  xie_pkg::res_t want;
  int   jump_limits[4] = '{127, 128, -128, -129};
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   cycle_count = 0;
  int   fail_count = 0;
  int   encoded_count = 0;
  int   ignored_count = 0;
  int   bytes_checked = 0;
  logic [23:0] forms_seen = '0;

  x86_64_instruction_encoder dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .req   (req),
    .empty (empty),
    .pop   (pop),
    .res   (res)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] rex_of(logic [3:0] reg_f, logic [3:0] rm_f);
    return xie_pkg::REX_W | {5'b0, reg_f[3], 1'b0, rm_f[3]};
  endfunction

  function automatic logic [7:0] modrm_of(logic [2:0] mid, logic [3:0] rm_f);
    return xie_pkg::MOD_REG | {2'b0, mid, rm_f[2:0]};
  endfunction

  function automatic void queue_request(logic [4:0] op, logic [3:0] a, logic [3:0] b,
                                        logic [63:0] imm);
    xie_pkg::req_t r;
    r.opcode = op;
    r.first_reg = a;
    r.second_reg = b;
    r.immediate = imm;
    pending_requests.insert(pending_requests.size(), r);
  endfunction

  function automatic void encode_instruction(xie_pkg::req_t r);
    logic [7:0]    code[$];
    logic [3:0]    a;
    logic [3:0]    b;
    logic [31:0]   lo;
    int            tail_len;
    int            i;
    xie_pkg::res_t word;
    a = r.first_reg;
    b = r.second_reg;
    lo = r.immediate[31:0];
    tail_len = 0;
    case (r.opcode)
      xie_pkg::OP_MOVIMM64: begin
        code = '{xie_pkg::REX_W | {7'b0, a[3]}, xie_pkg::OPC_MOVIMM + {5'b0, a[2:0]}};
        tail_len = 8;
      end
      xie_pkg::OP_MOVRR: code = '{rex_of(b, a), xie_pkg::OPC_MOVRM, modrm_of(b[2:0], a)};
      xie_pkg::OP_ADD:   code = '{rex_of(b, a), xie_pkg::OPC_ADD, modrm_of(b[2:0], a)};
      xie_pkg::OP_SUB:   code = '{rex_of(b, a), xie_pkg::OPC_SUB, modrm_of(b[2:0], a)};
      xie_pkg::OP_CMP:   code = '{rex_of(b, a), xie_pkg::OPC_CMP, modrm_of(b[2:0], a)};
      xie_pkg::OP_TEST:  code = '{rex_of(b, a), xie_pkg::OPC_TEST, modrm_of(b[2:0], a)};
      xie_pkg::OP_LOAD, xie_pkg::OP_LEA: begin
        code = '{rex_of(a, b),
                 (r.opcode == xie_pkg::OP_LOAD) ? xie_pkg::OPC_LOAD : xie_pkg::OPC_LEA,
                 xie_pkg::MOD_DISP32 | {2'b0, a[2:0], b[2:0]}};
        if (b[2:0] == xie_pkg::REG_RSP) code.insert(code.size(), xie_pkg::SIB_RSP);
        tail_len = 4;
      end
      xie_pkg::OP_IMUL:
        code = '{rex_of(a, b), xie_pkg::ESC_0F, xie_pkg::OPC_IMUL, modrm_of(a[2:0], b)};
      xie_pkg::OP_MOVZX:
        code = '{rex_of(a, b), xie_pkg::ESC_0F, xie_pkg::OPC_MOVZX, modrm_of(a[2:0], b)};
      xie_pkg::OP_CMPIMM, xie_pkg::OP_ADDIMM: begin
        if (a == 4'd0) begin
          code = '{xie_pkg::REX_W, (r.opcode == xie_pkg::OP_CMPIMM) ? xie_pkg::OPC_CMPACC
                                                                     : xie_pkg::OPC_ADDACC};
        end else begin
          code = '{rex_of(4'd0, a), xie_pkg::OPC_GRP1,
                   modrm_of((r.opcode == xie_pkg::OP_CMPIMM) ? xie_pkg::EXT_CMP
                                                             : xie_pkg::EXT_ADD, a)};
        end
        tail_len = 4;
      end
      xie_pkg::OP_JLE: begin
        code = '{xie_pkg::ESC_0F, xie_pkg::OPC_JLE};
        tail_len = 4;
      end
      xie_pkg::OP_JG: begin
        code = '{xie_pkg::ESC_0F, xie_pkg::OPC_JG};
        tail_len = 4;
      end
      xie_pkg::OP_JE: begin
        code = '{xie_pkg::ESC_0F, xie_pkg::OPC_JE};
        tail_len = 4;
      end
      xie_pkg::OP_JMP: begin
        if ($signed(lo) >= -128 && $signed(lo) <= 127) begin
          code = '{xie_pkg::OPC_JMP8};
          tail_len = 1;
        end else begin
          code = '{xie_pkg::OPC_JMP32};
          tail_len = 4;
        end
      end
      xie_pkg::OP_CALL:  code = '{xie_pkg::OPC_GRP5, modrm_of(xie_pkg::EXT_CALL, a)};
      xie_pkg::OP_RET:   code = '{xie_pkg::OPC_RET};
      xie_pkg::OP_PUSH:  code = '{xie_pkg::OPC_PUSH + {5'b0, a[2:0]}};
      xie_pkg::OP_POP:   code = '{xie_pkg::OPC_POP + {5'b0, a[2:0]}};
      xie_pkg::OP_SETLE: code = '{xie_pkg::ESC_0F, xie_pkg::OPC_SETLE, modrm_of(3'd0, a)};
      xie_pkg::OP_SETL:  code = '{xie_pkg::ESC_0F, xie_pkg::OPC_SETL, modrm_of(3'd0, a)};
      xie_pkg::OP_SETE:  code = '{xie_pkg::ESC_0F, xie_pkg::OPC_SETE, modrm_of(3'd0, a)};
      xie_pkg::OP_SETNE: code = '{xie_pkg::ESC_0F, xie_pkg::OPC_SETNE, modrm_of(3'd0, a)};
      default: ;
    endcase
    if (a[3] && r.opcode inside {xie_pkg::OP_CALL, xie_pkg::OP_PUSH, xie_pkg::OP_POP,
                                 xie_pkg::OP_SETLE, xie_pkg::OP_SETL, xie_pkg::OP_SETE,
                                 xie_pkg::OP_SETNE})
      code.push_front(xie_pkg::REX_B_ONLY);
    for (i = 0; i < tail_len; i++) code.insert(code.size(), r.immediate[8*i +: 8]);
    for (i = 0; i < code.size(); i++) begin
      word.code_byte = code[i];
      word.last_byte = (i == code.size() - 1);
      expected_bytes.insert(expected_bytes.size(), word);
    end
  endfunction

  function automatic void log_mismatch(string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      pop <= 1'b0;
    end else begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        req <= pending_requests[0];
      end else begin
        push <= 1'b0;
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end else if (!rst) begin
      if (push && !full) begin
        encode_instruction(req);
        void'(pending_requests.pop_front());
        if (req.opcode <= xie_pkg::OP_ADDIMM) begin
          encoded_count++;
          forms_seen[req.opcode] = 1'b1;
        end else begin
          ignored_count++;
        end
      end
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          log_mismatch($sformatf("unexpected word code_byte %02h last_byte %0b",
                                 res.code_byte, res.last_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (res.code_byte !== want.code_byte)
            log_mismatch($sformatf("word %0d code_byte expected %02h got %02h",
                                   bytes_checked, want.code_byte, res.code_byte));
          if (res.last_byte !== want.last_byte)
            log_mismatch($sformatf("word %0d last_byte expected %0b got %0b",
                                   bytes_checked, want.last_byte, res.last_byte));
        end
        bytes_checked++;
      end
    end
  end

  initial begin
    xie_pkg::req_t item;
    int   kept;
    int   phase;
    queue_request(xie_pkg::OP_MOVIMM64, 4'd15, 4'd0, 64'h8000_0000_0000_0000);
    queue_request(xie_pkg::OP_MOVRR, 4'd0, 4'd15, 64'h0);
    queue_request(xie_pkg::OP_LOAD, 4'd15, 4'd4, -64'sd1);
    queue_request(xie_pkg::OP_ADD, 4'd8, 4'd7, 64'h0);
    queue_request(xie_pkg::OP_SUB, 4'd7, 4'd8, 64'h0);
    queue_request(xie_pkg::OP_IMUL, 4'd12, 4'd5, 64'h0);
    queue_request(xie_pkg::OP_CMP, 4'd15, 4'd15, 64'h0);
    queue_request(xie_pkg::OP_CMPIMM, 4'd0, 4'd3, -64'sd2);
    queue_request(xie_pkg::OP_JLE, 4'd0, 4'd0, 64'h7FFF_FFFF_0000_0100);
    queue_request(xie_pkg::OP_JG, 4'd0, 4'd0, 64'hFFFF_FFFF_8000_0000);
    queue_request(xie_pkg::OP_JMP, 4'd0, 4'd0, 64'sd127);
    queue_request(xie_pkg::OP_JMP, 4'd0, 4'd0, -64'sd128);
    queue_request(xie_pkg::OP_JMP, 4'd0, 4'd0, -64'sd129);
    queue_request(xie_pkg::OP_CALL, 4'd13, 4'd0, 64'h0);
    queue_request(xie_pkg::OP_RET, 4'd0, 4'd0, 64'h0);
    queue_request(xie_pkg::OP_PUSH, 4'd8, 4'd0, 64'h0);
    queue_request(xie_pkg::OP_POP, 4'd7, 4'd0, 64'h0);
    queue_request(xie_pkg::OP_LEA, 4'd4, 4'd12, 64'h0000_0000_7FFF_FFFF);
    queue_request(xie_pkg::OP_TEST, 4'd1, 4'd2, 64'h0);
    queue_request(xie_pkg::OP_JE, 4'd0, 4'd0, 64'h0000_0000_1234_5678);
    queue_request(xie_pkg::OP_SETLE, 4'd15, 4'd0, 64'h0);
    queue_request(xie_pkg::OP_SETL, 4'd0, 4'd0, 64'h0);
    queue_request(xie_pkg::OP_SETE, 4'd11, 4'd0, 64'h0);
    queue_request(xie_pkg::OP_SETNE, 4'd3, 4'd0, 64'h0);
    queue_request(xie_pkg::OP_MOVZX, 4'd10, 4'd4, 64'h0);
    queue_request(xie_pkg::OP_ADDIMM, 4'd0, 4'd9, 64'h0000_0000_8000_0000);
    queue_request(5'd31, 4'd15, 4'd15, -64'sd1);
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 68 : 0;
      recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 9 : 0;
      kept = 0;
      while (kept < PHASE_ITEMS) begin
        item.opcode = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 24))
                                               : 5'($urandom_range(23));
        item.first_reg = 4'($urandom_range(15));
        item.second_reg = 4'($urandom_range(15));
        case ($urandom_range(3))
          0: item.immediate = {$urandom, $urandom};
          1: begin
            item.immediate = $urandom_range(600);
            item.immediate = item.immediate - 300;
          end
          2: item.immediate = {$urandom, 32'(jump_limits[$urandom_range(3)])};
          default: item.immediate = int'($urandom);
        endcase
        pending_requests.insert(pending_requests.size(), item);
        if (item.opcode <= xie_pkg::OP_ADDIMM) kept++;
      end
      while (pending_requests.size() != 0) @(posedge clk);
    end
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("encoded %0d instructions over %0d of 24 forms, %0d unused form codes dropped",
             encoded_count, $countones(forms_seen), ignored_count);
    $display("checked %0d code bytes under three idle profiles", bytes_checked);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/xie_pkg.sv
src/xie_front.sv
src/xie_queue.sv
src/xie_back.sv
src/x86_64_instruction_encoder.sv
sim/x86_64_instruction_encoder_test.sv
